>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; each macro takes a label, clock, reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/cle_pkg.sv
// Shared types and constants for the console line editor.
// Depends on nothing; used by cle_front, cle_back and console_line_editor.
package cle_pkg;

   localparam int unsigned RING_DEPTH = 128;
   localparam int unsigned SPAN       = 2 * RING_DEPTH;
   localparam int unsigned IDX_W      = $clog2(SPAN);
   localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

   localparam logic [7:0] KEY_KILL = 8'h15;
   localparam logic [7:0] KEY_BS   = 8'h08;
   localparam logic [7:0] KEY_DEL  = 8'h7F;
   localparam logic [7:0] KEY_EOF  = 8'h04;
   localparam logic [7:0] KEY_CR   = 8'h0D;
   localparam logic [7:0] KEY_LF   = 8'h0A;
   localparam logic [7:0] KEY_NUL  = 8'h00;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_READ,
      CLS_KILL,
      CLS_ERASE,
      CLS_STORE
   } cle_class_type;

   typedef struct packed {
      cle_class_type cls;
      logic [7:0]    ch;
   } cle_entry_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic [7:0] erase_count;
      logic       line_committed;
      logic       read_valid;
      logic [7:0] read_char;
   } cle_rsp_type;

endpackage

>>> hw/rtl/cle_front.sv
// Front end: classifies incoming beats and holds them in a short queue.
// Depends on cle_pkg for the key codes, class enum and queue entry type.
module cle_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [7:0]             req_rx_byte,
   output logic                   q_valid,
   input  logic                   q_pop,
   output cle_pkg::cle_entry_type q_entry
);

   cle_pkg::cle_entry_type              cls_entry;
   cle_pkg::cle_entry_type              ent_ff [cle_pkg::Q_DEPTH];
   logic [cle_pkg::Q_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [cle_pkg::Q_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [cle_pkg::Q_PTR_W:0]           count_ff, count_in;
   logic                                push, pop;

   localparam logic [cle_pkg::Q_PTR_W:0]   Q_FULL = (cle_pkg::Q_PTR_W+1)'(cle_pkg::Q_DEPTH);
   localparam logic [cle_pkg::Q_PTR_W-1:0] Q_LAST = cle_pkg::Q_PTR_W'(cle_pkg::Q_DEPTH - 1);

   // Classify the beat; map CR to LF for stored bytes.
   always_comb begin
      cls_entry.ch  = req_rx_byte;
      cls_entry.cls = cle_pkg::CLS_STORE;
      if (req_kind) begin
         cls_entry.cls = cle_pkg::CLS_READ;
      end else begin
         unique case (req_rx_byte) inside
            cle_pkg::KEY_KILL:                 cls_entry.cls = cle_pkg::CLS_KILL;
            cle_pkg::KEY_BS, cle_pkg::KEY_DEL: cls_entry.cls = cle_pkg::CLS_ERASE;
            cle_pkg::KEY_NUL:                  cls_entry.cls = cle_pkg::CLS_NONE;
            cle_pkg::KEY_CR:                   cls_entry.ch  = cle_pkg::KEY_LF;
            default:                           cls_entry.cls = cle_pkg::CLS_STORE;
         endcase
      end
   end

   assign req_ready = (count_ff != Q_FULL);
   assign q_valid   = (count_ff != '0);
   assign q_entry   = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cls_entry;
      end
   end

endmodule

>>> hw/rtl/cle_back.sv
// Back end: executes queued beats against the line ring and its three indices.
// Depends on cle_pkg for the ring geometry, class enum and response type.
module cle_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  cle_pkg::cle_entry_type q_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cle_pkg::cle_rsp_type   rsp
);

   localparam int unsigned IW = cle_pkg::IDX_W;
   localparam int unsigned SW = cle_pkg::SLOT_W;
   localparam logic [IW:0]   SPAN_X  = (IW+1)'(cle_pkg::SPAN);
   localparam logic [IW-1:0] DEPTH_I = IW'(cle_pkg::RING_DEPTH);

   typedef enum logic {ST_IDLE, ST_RESP} state_type;

   function automatic logic [IW-1:0] idx_inc(logic [IW-1:0] i);
      logic [IW:0] w;
      w = {1'b0, i} + 1'b1;
      return (w >= SPAN_X) ? '0 : w[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] idx_dec(logic [IW-1:0] i);
      logic [IW:0] w;
      w = SPAN_X - 1'b1;
      return (i == '0) ? w[IW-1:0] : i - 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dist(logic [IW-1:0] a, logic [IW-1:0] b);
      logic [IW:0] w;
      if (a >= b) begin
         w = {1'b0, a} - {1'b0, b};
      end else begin
         w = {1'b0, a} + SPAN_X - {1'b0, b};
      end
      return w[IW-1:0];
   endfunction

   function automatic logic [SW-1:0] idx_slot(logic [IW-1:0] i);
      logic [IW-1:0] s;
      s = (i >= DEPTH_I) ? i - DEPTH_I : i;
      return s[SW-1:0];
   endfunction

   logic [7:0]    ring_mem [cle_pkg::RING_DEPTH];
   logic [7:0]    rd_data_ff;

   state_type     state_ff, state_in;
   logic [IW-1:0] read_ff, read_in;
   logic [IW-1:0] commit_ff, commit_in;
   logic [IW-1:0] edit_ff, edit_in;
   logic          echo_valid_ff, echo_valid_in;
   logic [7:0]    echo_char_ff, echo_char_in;
   logic [7:0]    erase_ff, erase_in;
   logic          commit_flag_ff, commit_flag_in;
   logic          read_valid_ff, read_valid_in;

   logic          take, wr_en, rd_en;
   logic [IW-1:0] edit_next, kill_dist;
   logic [31:0]   kill_wide;

   assign take      = (state_ff == ST_IDLE) && q_valid;
   assign q_pop     = take;
   assign edit_next = idx_inc(edit_ff);
   assign kill_dist = idx_dist(edit_ff, commit_ff);
   assign kill_wide = 32'(kill_dist);

   always_comb begin
      state_in       = state_ff;
      read_in        = read_ff;
      commit_in      = commit_ff;
      edit_in        = edit_ff;
      echo_valid_in  = echo_valid_ff;
      echo_char_in   = echo_char_ff;
      erase_in       = erase_ff;
      commit_flag_in = commit_flag_ff;
      read_valid_in  = read_valid_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in       = ST_RESP;
               echo_valid_in  = 1'b0;
               echo_char_in   = '0;
               erase_in       = '0;
               commit_flag_in = 1'b0;
               read_valid_in  = 1'b0;
               case (q_entry.cls)
                  cle_pkg::CLS_READ: begin
                     if (read_ff != commit_ff) begin
                        read_valid_in = 1'b1;
                        rd_en         = 1'b1;
                        read_in       = idx_inc(read_ff);
                     end
                  end
                  cle_pkg::CLS_KILL: begin
                     erase_in = (kill_wide > 32'd255) ? 8'hFF : kill_wide[7:0];
                     edit_in  = commit_ff;
                  end
                  cle_pkg::CLS_ERASE: begin
                     if (edit_ff != commit_ff) begin
                        edit_in  = idx_dec(edit_ff);
                        erase_in = 8'd1;
                     end
                  end
                  cle_pkg::CLS_STORE: begin
                     if (idx_dist(edit_ff, read_ff) < DEPTH_I) begin
                        wr_en         = 1'b1;
                        edit_in       = edit_next;
                        echo_valid_in = 1'b1;
                        echo_char_in  = q_entry.ch;
                        if (q_entry.ch == cle_pkg::KEY_LF || q_entry.ch == cle_pkg::KEY_EOF ||
                            idx_dist(edit_next, read_ff) == DEPTH_I) begin
                           commit_in      = edit_next;
                           commit_flag_in = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
      echo_valid_ff  <= echo_valid_in;
      echo_char_ff   <= echo_char_in;
      erase_ff       <= erase_in;
      commit_flag_ff <= commit_flag_in;
      read_valid_ff  <= read_valid_in;
   end

   // Ring storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[idx_slot(edit_ff)] <= q_entry.ch;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[idx_slot(read_ff)];
      end
   end

   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp.echo_valid     = echo_valid_ff;
   assign rsp.echo_char      = echo_char_ff;
   assign rsp.erase_count    = erase_ff;
   assign rsp.line_committed = commit_flag_ff;
   assign rsp.read_valid     = read_valid_ff;
   assign rsp.read_char      = read_valid_ff ? rd_data_ff : '0;

endmodule

>>> hw/rtl/console_line_editor.sv
// Console line editor: terminal input line discipline, top level.
// Depends on cle_pkg, cle_front and cle_back.
//
// Usage:
//   req_ channel: one beat per received terminal byte (req_kind = 0) or per
//   read request for the next committed byte (req_kind = 1).
//   rsp_ channel: exactly one result beat per request beat, in order, with
//   echo, erase, commit and read fields.
// Sequencing: an accepted beat is written into the front queue, then executed
//   by the back end, whose registered result (with the ring memory's registered
//   read port for read data) is offered on rsp_. The back end takes a new beat
//   only once the previous result has been taken; its execute-then-deliver
//   sequencer sets the throughput.
// The front holds up to two classified beats, so requests keep being taken
//   while a result waits on rsp_ready; when the queue fills, req_ready drops.
// A stalled result holds its payload until taken.
// Reset clears the read, commit and edit indices and empties the queue; the
//   ring contents are left as they are, since only committed (hence written)
//   entries are ever read.
module console_line_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_char,
   output logic [7:0] rsp_erase_count,
   output logic       rsp_line_committed,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_char
);

   logic                   q_valid;
   logic                   q_pop;
   cle_pkg::cle_entry_type q_entry;
   cle_pkg::cle_rsp_type   rsp;

   // Accept and classify beats; hold them until the back end is free.
   cle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_rx_byte(req_rx_byte),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_entry    (q_entry)
   );

   // Advance the indices, touch the ring and register the result beat.
   cle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_entry  (q_entry),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   assign rsp_echo_valid     = rsp.echo_valid;
   assign rsp_echo_char      = rsp.echo_char;
   assign rsp_erase_count    = rsp.erase_count;
   assign rsp_line_committed = rsp.line_committed;
   assign rsp_read_valid     = rsp.read_valid;
   assign rsp_read_char      = rsp.read_char;

endmodule

>>> hw/rtl/cle_checker.sv
// Port-level checker for the console line editor, bound to the top level.
// Depends on assert_macros.svh and console_line_editor's port list.
`include "assert_macros.svh"

module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_echo_valid,
   input logic [7:0] rsp_echo_char,
   input logic [7:0] rsp_erase_count,
   input logic       rsp_line_committed,
   input logic       rsp_read_valid,
   input logic [7:0] rsp_read_char
);

   logic rsp_quiet;
   logic rsp_clean;

   assign rsp_quiet = !rsp_echo_valid && (rsp_erase_count == 8'd0) && !rsp_line_committed;
   assign rsp_clean = (rsp_read_valid || (rsp_read_char == 8'd0)) &&
                      (rsp_echo_valid || (rsp_echo_char == 8'd0));

   // A stalled request beat stays offered.
   `AST_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid)

   // A stalled result beat stays offered.
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A read result carries no echo, erase or commit.
   `AST_IMPL(a_read_alone, clock, reset, rsp_valid && rsp_read_valid, rsp_quiet)

   // Only a stored, echoed byte commits a line.
   `AST_IMPL(a_commit_echo, clock, reset, rsp_valid && rsp_line_committed, rsp_echo_valid)

   // No echo or read data without its valid flag.
   `AST_IMPL(a_data_zero, clock, reset, rsp_valid, rsp_clean)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
